### src/tapq_pkg.sv
// Shared types and constants for the triangle area, perimeter and quality unit.
`timescale 1ns / 1ps
package tapq_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int DA_W = 33;
    localparam int PER_W = 27;
    localparam int Q_W = 17;
    localparam int FRAC_BITS = 8;
    localparam int QUO_BITS = 32;
    localparam int K_SHIFT = 45;
    localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
    } t_tri_in;

    typedef struct packed {
        logic [DA_W-1:0]  double_area;
        logic [PER_W-1:0] perimeter_q8;
        logic [Q_W-1:0]   quality_q16;
        logic             degenerate;
    } t_tri_res;

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    localparam logic [31:0] K_SQRT12 = 32'(isqrt64(64'd12 << 58));

endpackage

### src/tapq_front.sv
// Front end: edge vectors, products, absolute cross product and squared sides.
`timescale 1ns / 1ps
module tapq_front #(
    parameter int COORD_BITS = tapq_pkg::COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_v,
    input  tapq_pkg::t_tri_in         i_req,
    output logic                      o_v,
    output logic [2*COORD_BITS+1:0]   o_d,
    output logic [2*COORD_BITS+1:0]   o_s1,
    output logic [2*COORD_BITS+1:0]   o_s2,
    output logic [2*COORD_BITS+1:0]   o_s3
);
    import tapq_pkg::*;

    localparam int W = COORD_BITS;
    localparam int EW = W + 1;
    localparam int PW = 2 * W + 2;

    logic signed [W-1:0] w_ax, w_ay, w_bx, w_by, w_cx, w_cy;
    logic signed [EW-1:0] n_d1x, n_d1y, n_d2x, n_d2y, n_d3x, n_d3y;
    logic signed [EW-1:0] r_d1x, r_d1y, r_d2x, r_d2y, r_d3x, r_d3y;
    logic signed [PW-1:0] n_p1, n_p2, n_q1x, n_q1y, n_q2x, n_q2y, n_q3x, n_q3y;
    logic signed [PW-1:0] r_p1, r_p2, r_q1x, r_q1y, r_q2x, r_q2y, r_q3x, r_q3y;
    logic signed [PW:0]   w_cross;
    logic [PW-1:0]        n_d, n_s1, n_s2, n_s3;
    logic [PW-1:0]        r_d, r_s1, r_s2, r_s3;
    logic [2:0]           r_v;

    assign w_ax = W'($unsigned(i_req.ax));
    assign w_ay = W'($unsigned(i_req.ay));
    assign w_bx = W'($unsigned(i_req.bx));
    assign w_by = W'($unsigned(i_req.by));
    assign w_cx = W'($unsigned(i_req.cx));
    assign w_cy = W'($unsigned(i_req.cy));

    assign n_d1x = EW'(w_bx) - EW'(w_ax);
    assign n_d1y = EW'(w_by) - EW'(w_ay);
    assign n_d2x = EW'(w_cx) - EW'(w_ax);
    assign n_d2y = EW'(w_cy) - EW'(w_ay);
    assign n_d3x = EW'(w_cx) - EW'(w_bx);
    assign n_d3y = EW'(w_cy) - EW'(w_by);

    assign n_p1  = PW'(r_d1x) * PW'(r_d2y);
    assign n_p2  = PW'(r_d1y) * PW'(r_d2x);
    assign n_q1x = PW'(r_d1x) * PW'(r_d1x);
    assign n_q1y = PW'(r_d1y) * PW'(r_d1y);
    assign n_q2x = PW'(r_d2x) * PW'(r_d2x);
    assign n_q2y = PW'(r_d2y) * PW'(r_d2y);
    assign n_q3x = PW'(r_d3x) * PW'(r_d3x);
    assign n_q3y = PW'(r_d3y) * PW'(r_d3y);

    assign w_cross = (PW+1)'(r_p1) - (PW+1)'(r_p2);
    assign n_d  = w_cross[PW] ? PW'(-w_cross) : PW'(w_cross);
    assign n_s1 = $unsigned(r_q1x) + $unsigned(r_q1y);
    assign n_s2 = $unsigned(r_q2x) + $unsigned(r_q2y);
    assign n_s3 = $unsigned(r_q3x) + $unsigned(r_q3y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_v};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1x <= n_d1x;
        r_d1y <= n_d1y;
        r_d2x <= n_d2x;
        r_d2y <= n_d2y;
        r_d3x <= n_d3x;
        r_d3y <= n_d3y;
        r_p1  <= n_p1;
        r_p2  <= n_p2;
        r_q1x <= n_q1x;
        r_q1y <= n_q1y;
        r_q2x <= n_q2x;
        r_q2y <= n_q2y;
        r_q3x <= n_q3x;
        r_q3y <= n_q3y;
        r_d   <= n_d;
        r_s1  <= n_s1;
        r_s2  <= n_s2;
        r_s3  <= n_s3;
    end

    assign o_v  = r_v[2];
    assign o_d  = r_d;
    assign o_s1 = r_s1;
    assign o_s2 = r_s2;
    assign o_s3 = r_s3;

endmodule

### src/tapq_sqrt.sv
// Pipelined square root of a squared side, one result bit per stage, 8 fraction bits.
`timescale 1ns / 1ps
module tapq_sqrt #(
    parameter int IN_W = 34
) (
    input  logic                                 i_clk,
    input  logic [IN_W-1:0]                      i_x,
    output logic [IN_W/2+tapq_pkg::FRAC_BITS-1:0] o_root
);
    import tapq_pkg::*;

    localparam int XW = IN_W + 2 * FRAC_BITS;
    localparam int RB = XW / 2;
    localparam int RMW = RB + 2;

    logic [RMW-1:0] r_rem  [RB];
    logic [RB-1:0]  r_root [RB];
    logic [XW-1:0]  r_x    [RB];

    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [RMW-1:0] w_rem_in;
        logic [RB-1:0]  w_root_in;
        logic [XW-1:0]  w_x_in;
        logic [RMW-1:0] w_rem_t;
        logic [RMW-1:0] w_trial;
        logic           w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_x_in    = {i_x, {(2*FRAC_BITS){1'b0}}};
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_x_in    = r_x[k-1];
        end

        assign w_rem_t = {w_rem_in[RMW-3:0], w_x_in[XW-1 -: 2]};
        assign w_trial = {w_root_in, 2'b01};
        assign w_ge    = (w_rem_t >= w_trial);

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= w_ge ? (w_rem_t - w_trial) : w_rem_t;
            r_root[k] <= {w_root_in[RB-2:0], w_ge};
            r_x[k]    <= {w_x_in[XW-3:0], 2'b00};
        end
    end

    assign o_root = r_root[RB-1];

endmodule

### src/tapq_div.sv
// Pipelined restoring divider forming double_area * 2^32 / S, with alignment stages.
`timescale 1ns / 1ps
module tapq_div #(
    parameter int QW  = 34,
    parameter int PAD = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_v,
    input  logic [QW-1:0]                   i_d,
    input  logic [QW-1:0]                   i_s1,
    input  logic [QW-1:0]                   i_s2,
    input  logic [QW-1:0]                   i_s3,
    output logic                            o_v,
    output logic [QW-1:0]                   o_d,
    output logic                            o_degen,
    output logic                            o_sat,
    output logic [tapq_pkg::QUO_BITS-1:0]   o_t
);
    import tapq_pkg::*;

    localparam int SW = QW + 1;
    localparam int NS = QUO_BITS + 1 + PAD;

    logic [SW-1:0]       w_sum;
    logic                w_sat;

    logic                r_v     [NS];
    logic [QW-1:0]       r_d     [NS];
    logic                r_degen [NS];
    logic                r_sat   [NS];
    logic [SW-1:0]       r_s     [NS];
    logic [SW-1:0]       r_r     [NS];
    logic [QUO_BITS-1:0] r_t     [NS];

    assign w_sum = SW'(i_s1) + SW'(i_s2) + SW'(i_s3);
    assign w_sat = (SW'(i_d) >= w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d[0]     <= i_d;
        r_degen[0] <= (w_sum == '0);
        r_sat[0]   <= w_sat;
        r_s[0]     <= w_sum;
        r_r[0]     <= w_sat ? '0 : SW'(i_d);
        r_t[0]     <= '0;
    end

    for (genvar k = 1; k < NS; k++) begin : g_stage
        logic [SW:0] w_r2;
        logic        w_ge;

        assign w_r2 = {r_r[k-1], 1'b0};
        assign w_ge = (w_r2 >= {1'b0, r_s[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
        end

        if (k <= QUO_BITS) begin : g_div
            always_ff @(posedge i_clk) begin
                r_r[k] <= w_ge ? SW'(w_r2 - {1'b0, r_s[k-1]}) : w_r2[SW-1:0];
                r_t[k] <= {r_t[k-1][QUO_BITS-2:0], w_ge};
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                r_r[k] <= r_r[k-1];
                r_t[k] <= r_t[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_d[k]     <= r_d[k-1];
            r_degen[k] <= r_degen[k-1];
            r_sat[k]   <= r_sat[k-1];
            r_s[k]     <= r_s[k-1];
        end
    end

    assign o_v     = r_v[NS-1];
    assign o_d     = r_d[NS-1];
    assign o_degen = r_degen[NS-1];
    assign o_sat   = r_sat[NS-1];
    assign o_t     = r_t[NS-1];

endmodule

### src/tapq_delay.sv
// Fixed-length register delay line for payload alignment.
`timescale 1ns / 1ps
module tapq_delay #(
    parameter int DW = 8,
    parameter int N  = 1
) (
    input  logic          i_clk,
    input  logic [DW-1:0] i_data,
    output logic [DW-1:0] o_data
);
    import tapq_pkg::*;

    if (N == 0) begin : g_none
        assign o_data = i_data;
    end else begin : g_line
        logic [DW-1:0] r_tap [N];

        always_ff @(posedge i_clk) begin
            r_tap[0] <= i_data;
        end

        for (genvar k = 1; k < N; k++) begin : g_tap
            always_ff @(posedge i_clk) begin
                r_tap[k] <= r_tap[k-1];
            end
        end

        assign o_data = r_tap[N-1];
    end

endmodule

### src/triangle_area_perimeter_quality_unit.sv
// Top level of the triangle area, perimeter and quality pipeline.
//
// Usage: present a triangle on i_req and raise i_start; the request is taken
// at any rising edge where i_start is high and o_busy is low. o_busy is high
// only during reset and the cycle after, so one request can enter every cycle.
// Each result appears on o_res for exactly one cycle with o_done high; the
// receiver cannot hold it off and must capture it then.
// The quality ratio is formed by the divider and its 32 division stages;
// the perimeter square roots run alongside it, one root bit per stage.
// Throughput: one triangle per cycle while o_busy is low.
// Reset: synchronous, active low; clears all valid bits so no stray o_done
// is produced. Results of requests in flight at reset are dropped.
// Degenerate triangles (all vertices equal) give degenerate = 1, quality 0.
`timescale 1ns / 1ps
module triangle_area_perimeter_quality_unit #(
    parameter int COORD_BITS = tapq_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  tapq_pkg::t_tri_in   i_req,
    output logic                o_busy,
    output logic                o_done,
    output tapq_pkg::t_tri_res  o_res
);
    import tapq_pkg::*;

    localparam int QW  = 2 * COORD_BITS + 2;
    localparam int RB  = QW / 2 + FRAC_BITS;
    localparam int PSW = RB + 2;
    localparam int LS  = RB + 1;
    localparam int LD  = QUO_BITS + 1;
    localparam int L   = (LS > LD) ? LS : LD;

    logic           r_busy;
    logic           w_fv;
    logic [QW-1:0]  w_d, w_s1, w_s2, w_s3;
    logic [RB-1:0]  w_l1, w_l2, w_l3;
    logic [PSW-1:0] r_per;
    logic [PSW-1:0] w_per_al;
    logic           w_dv;
    logic [QW-1:0]  w_dd;
    logic           w_degen, w_sat;
    logic [QUO_BITS-1:0] w_t;

    logic           r_mv;
    logic [63:0]    r_prod;
    logic [QW-1:0]  r_md;
    logic           r_mdegen, r_msat;
    logic [PSW-1:0] r_mper;

    logic           r_ov;
    t_tri_res       r_res;
    logic [18:0]    w_qraw;
    logic [Q_W-1:0] n_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    tapq_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (i_start & ~r_busy),
        .i_req   (i_req),
        .o_v     (w_fv),
        .o_d     (w_d),
        .o_s1    (w_s1),
        .o_s2    (w_s2),
        .o_s3    (w_s3)
    );

    tapq_sqrt #(.IN_W(QW)) u_sqrt1 (.i_clk(i_clk), .i_x(w_s1), .o_root(w_l1));
    tapq_sqrt #(.IN_W(QW)) u_sqrt2 (.i_clk(i_clk), .i_x(w_s2), .o_root(w_l2));
    tapq_sqrt #(.IN_W(QW)) u_sqrt3 (.i_clk(i_clk), .i_x(w_s3), .o_root(w_l3));

    always_ff @(posedge i_clk) begin
        r_per <= PSW'(w_l1) + PSW'(w_l2) + PSW'(w_l3);
    end

    tapq_delay #(.DW(PSW), .N(L - LS)) u_per_dly (
        .i_clk  (i_clk),
        .i_data (r_per),
        .o_data (w_per_al)
    );

    tapq_div #(.QW(QW), .PAD(L - LD)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (w_fv),
        .i_d     (w_d),
        .i_s1    (w_s1),
        .i_s2    (w_s2),
        .i_s3    (w_s3),
        .o_v     (w_dv),
        .o_d     (w_dd),
        .o_degen (w_degen),
        .o_sat   (w_sat),
        .o_t     (w_t)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_mv <= w_dv;
            r_ov <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= 64'(w_t) * 64'(K_SQRT12);
        r_md     <= w_dd;
        r_mdegen <= w_degen;
        r_msat   <= w_sat;
        r_mper   <= w_per_al;
    end

    assign w_qraw = r_prod[K_SHIFT +: 19];

    always_comb begin
        priority if (r_mdegen) begin
            n_q = '0;
        end else if (r_msat || (w_qraw > 19'(Q_ONE))) begin
            n_q = Q_ONE;
        end else begin
            n_q = Q_W'(w_qraw);
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.double_area  <= DA_W'(r_md);
        r_res.perimeter_q8 <= PER_W'(r_mper);
        r_res.quality_q16  <= n_q;
        r_res.degenerate   <= r_mdegen;
    end

    assign o_busy = r_busy;
    assign o_done = r_ov;
    assign o_res  = r_res;

endmodule

### verif/triangle_area_perimeter_quality_unit_tb.sv
// Self-checking testbench for the triangle area, perimeter and quality unit.
`timescale 1ns / 1ps
module triangle_area_perimeter_quality_unit_tb;
    import tapq_pkg::*;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_start = 1'b0;
    t_tri_in  i_req = '0;
    logic     o_busy;
    logic     o_done;
    t_tri_res o_res;

    t_tri_in  pending_tris[$];
    t_tri_res expected_metrics[$];
    int       errors = 0;
    int       idle_pct = 0;
    logic     feed_done = 1'b0;

    triangle_area_perimeter_quality_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_req  (i_req),
        .o_busy (o_busy),
        .o_done (o_done),
        .o_res  (o_res)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [63:0] int_root(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] side_q8(input logic [63:0] sq);
        logic [63:0] s;
        logic [63:0] lim;
        logic [63:0] f;
        logic [63:0] c;
        s = int_root(sq);
        lim = (sq - s * s) << 16;
        f = 0;
        for (int b = 7; b >= 0; b--) begin
            c = f | (64'd1 << b);
            if (512 * s * c + c * c <= lim) f = c;
        end
        return (s << 8) | f;
    endfunction

    function automatic t_tri_res tri_metrics(input t_tri_in t);
        longint    dxb, dyb, dxc, dyc, cr;
        logic [63:0] d, s1, s2, s3, s, rem, quo, k, q;
        t_tri_res  m;
        dxb = longint'(t.bx) - t.ax;
        dyb = longint'(t.by) - t.ay;
        dxc = longint'(t.cx) - t.ax;
        dyc = longint'(t.cy) - t.ay;
        cr = dxb * dyc - dyb * dxc;
        d = (cr < 0) ? -cr : cr;
        s1 = dxb * dxb + dyb * dyb;
        s2 = dxc * dxc + dyc * dyc;
        s3 = (dxc - dxb) * (dxc - dxb) + (dyc - dyb) * (dyc - dyb);
        s = s1 + s2 + s3;
        q = 0;
        if (s != 0) begin
            k = int_root(64'd12 << 58);
            rem = d % s;
            quo = 0;
            for (int i = 0; i < 32; i++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= s) begin
                    rem = rem - s;
                    quo = quo | 1;
                end
            end
            if (d / s != 0 || quo >= 64'h1_0000_0000) begin
                q = 65536;
            end else begin
                q = (quo * k) >> 45;
                if (q > 65536) q = 65536;
            end
        end
        m.double_area = d[DA_W-1:0];
        m.perimeter_q8 = PER_W'(side_q8(s1) + side_q8(s2) + side_q8(s3));
        m.quality_q16 = q[Q_W-1:0];
        m.degenerate = (s == 0);
        return m;
    endfunction

    function automatic logic signed [15:0] rand_coord(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 40)) - 16'sd20;
            default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    task automatic add_tri(input int ax, ay, bx, by, cx, cy);
        t_tri_in t;
        t.ax = 16'(ax); t.ay = 16'(ay);
        t.bx = 16'(bx); t.by = 16'(by);
        t.cx = 16'(cx); t.cy = 16'(cy);
        pending_tris.push_back(t);
    endtask

    initial begin
        t_tri_in t;
        int      mode;
        int      base;
        add_tri(0, 0, 0, 0, 0, 0);
        add_tri(1234, -99, 1234, -99, 1234, -99);
        add_tri(0, 0, 1, 1, 2, 2);
        add_tri(-5, 3, 10, 3, 40, 3);
        add_tri(0, 0, 1000, 0, 500, 866);
        add_tri(0, 0, 15000, 0, 7500, 12990);
        add_tri(0, 0, 3, 0, 0, 4);
        add_tri(-32768, -32768, 32767, -32768, -32768, 32767);
        add_tri(32767, 32767, -32768, 32767, 32767, -32768);
        add_tri(-32768, -32768, 32767, 32767, -32768, 32767);
        add_tri(-32768, 0, 32767, 0, 0, 32767);
        add_tri(32767, 32767, 32767, 32767, -32768, -32768);
        add_tri(-1, -1, -1, -1, -1, -1);
        add_tri(0, 0, 1, 0, 0, 1);
        add_tri(0, 0, 2, 0, 1, 2);
        add_tri(100, 200, -300, 400, 500, -600);
        for (int i = 0; i < 1750; i++) begin
            mode = $urandom_range(0, 9);
            if (mode < 5) begin
                t.ax = rand_coord(0); t.ay = rand_coord(0);
                t.bx = rand_coord(0); t.by = rand_coord(0);
                t.cx = rand_coord(0); t.cy = rand_coord(0);
            end else if (mode < 7) begin
                base = $urandom_range(0, 60000) - 30000;
                t.ax = 16'(base) + rand_coord(1); t.ay = 16'(base) + rand_coord(1);
                t.bx = 16'(base) + rand_coord(1); t.by = 16'(base) + rand_coord(1);
                t.cx = 16'(base) + rand_coord(1); t.cy = 16'(base) + rand_coord(1);
            end else if (mode == 7) begin
                t.ax = rand_coord(2); t.ay = rand_coord(2);
                t.bx = rand_coord(2); t.by = rand_coord(2);
                t.cx = rand_coord(2); t.cy = rand_coord(2);
            end else if (mode == 8) begin
                t.ax = rand_coord(0); t.ay = rand_coord(0);
                t.bx = rand_coord(0); t.by = t.ay;
                t.cx = rand_coord(0); t.cy = t.ay;
            end else begin
                t.ax = rand_coord(0); t.ay = rand_coord(0);
                t.bx = t.ax; t.by = t.ay; t.cx = t.ax; t.cy = t.ay;
            end
            pending_tris.push_back(t);
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_tris.size() != 0) begin
            @(posedge i_clk);
            case (($urandom_range(0, 3) + pending_tris.size() / 200) % 4)
                0: idle_pct = 0;
                1: idle_pct = 52;
                2: idle_pct = 30;
                default: idle_pct = 0;
            endcase
            repeat (150) @(posedge i_clk);
        end
        feed_done <= 1'b1;
    end

    always @(negedge i_clk) begin
        if (i_rst_n && pending_tris.size() != 0 && !(i_start && o_busy)) begin
            if ($urandom_range(0, 99) < idle_pct) begin
                i_start <= 1'b0;
            end else begin
                i_start <= 1'b1;
                i_req <= pending_tris[0];
            end
        end else if (!(i_start && o_busy)) begin
            i_start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_tri_res want;
        if (i_rst_n && i_start && !o_busy) begin
            expected_metrics.push_back(tri_metrics(i_req));
            void'(pending_tris.pop_front());
        end
        if (i_rst_n && o_done) begin
            if (expected_metrics.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_res);
                errors++;
            end else begin
                want = expected_metrics.pop_front();
                if (o_res.double_area !== want.double_area)
                    $display("%0t: double_area expected %0d actual %0d",
                             $time, want.double_area, o_res.double_area);
                if (o_res.perimeter_q8 !== want.perimeter_q8)
                    $display("%0t: perimeter_q8 expected %0d actual %0d",
                             $time, want.perimeter_q8, o_res.perimeter_q8);
                if (o_res.quality_q16 !== want.quality_q16)
                    $display("%0t: quality_q16 expected %0d actual %0d",
                             $time, want.quality_q16, o_res.quality_q16);
                if (o_res.degenerate !== want.degenerate)
                    $display("%0t: degenerate expected %0d actual %0d",
                             $time, want.degenerate, o_res.degenerate);
                if (o_res !== want) errors++;
            end
        end
    end

    initial begin
        wait (feed_done);
        wait (pending_tris.size() == 0);
        @(posedge i_clk);
        wait (expected_metrics.size() == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && expected_metrics.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("status: fail");
        $finish;
    end

endmodule

### files.f
src/tapq_pkg.sv
src/tapq_front.sv
src/tapq_sqrt.sv
src/tapq_div.sv
src/tapq_delay.sv
src/triangle_area_perimeter_quality_unit.sv
verif/triangle_area_perimeter_quality_unit_tb.sv
